>>> rtl/sppe_pkg.sv
// ----------------------------------------------------------------------------
// sppe_pkg
// Shared widths, register indexes, reset values and control types for the
// stereo ping-pong echo.
// ----------------------------------------------------------------------------
package sppe_pkg;

  localparam int IN_W      = 24;  // input sample width
  localparam int OUT_W     = 26;  // output sample width
  localparam int OFF_W     = 18;  // delay offset register width
  localparam int GAIN_W    = 17;  // feedback gain register width (Q1.16)
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 18;

  localparam logic [OFF_W-1:0]  OFFSET_RESET = 18'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = 17'd32768;

  // 0.7 in Q0.16
  localparam logic [15:0] DRY_GAIN = 16'd45875;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_OFFSET  = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1
  } cfg_reg_e;

  // Reasons the datapath must not take a request
  typedef struct packed {
    logic clear;     // echo store clearing pass running
    logic cfg_busy;  // offset reduction running
  } hold_t;

  // Echo store port strobes
  typedef struct packed {
    logic re;
    logic we;
  } mem_ctl_t;

endpackage

>>> rtl/stereo_ping_pong_echo.sv
// ----------------------------------------------------------------------------
// stereo_ping_pong_echo
// Mono in, stereo ping-pong echo out, one circular echo store in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_sample_i) takes one signed
//   mono sample per request; the output channel (out_valid_o / out_stall_i)
//   returns one left/right pair per request, in order.
//   Each request passes stages s1 to s3; its result is then registered in
//   the result buffer. A new request waits until the three reads (tap,
//   left slot, right slot) of the last sample on the store's single read
//   port are done; a sample's right write-back can overlap the next one's reads.
//   A two-entry result buffer lets the block keep taking requests while a
//   result waits; with the receiver stalled it takes at most two requests
//   ahead, then raises in_stall_o until results drain.
//   Reset: the echo store is cleared in one pass over all DEPTH words, one
//   word a cycle, with in_stall_o high. Configuration writes are taken
//   meanwhile. A delay_offset write reduces the offset modulo DEPTH, with
//   cfg_ready_o low and in_stall_o high; a feedback_gain write takes effect
//   at once. Write configuration only while no sample is in flight.
// ----------------------------------------------------------------------------
module stereo_ping_pong_echo #(
  parameter int DEPTH       = 131072,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sppe_pkg::IN_W-1:0]    in_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sppe_pkg::OUT_W-1:0]   left_sample_o,
  output logic signed [sppe_pkg::OUT_W-1:0]   right_sample_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sppe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sppe_pkg::CFG_W-1:0]          cfg_data_i
);

  import sppe_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              clr_q;
  logic [AW-1:0]     clr_addr_q;
  hold_t             hold;
  logic              cfg_busy;
  logic              take;
  logic [GAIN_W-1:0] gain;
  logic [AW-1:0]     rp, wl, wr;
  mem_ctl_t          dp_mem;
  logic [AW-1:0]     dp_raddr, dp_waddr;
  logic [SAMPLE_BITS-1:0] dp_wdata, rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign hold.clear    = clr_q;
  assign hold.cfg_busy = cfg_busy;

  assign mem_we    = clr_q || dp_mem.we;
  assign mem_waddr = clr_q ? clr_addr_q : dp_waddr;
  assign mem_wdata = clr_q ? '0 : dp_wdata;

  sppe_ptr #(
    .DEPTH (DEPTH)
  ) u_ptr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .busy_o      (cfg_busy),
    .gain_o      (gain),
    .rp_o        (rp),
    .wl_o        (wl),
    .wr_o        (wr)
  );

  sppe_dp #(
    .DEPTH (DEPTH),
    .SB    (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .hold_i         (hold),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_sample_i    (in_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .take_o         (take),
    .gain_i         (gain),
    .rp_i           (rp),
    .wl_i           (wl),
    .wr_i           (wr),
    .mem_o          (dp_mem),
    .raddr_o        (dp_raddr),
    .waddr_o        (dp_waddr),
    .wdata_o        (dp_wdata),
    .rdata_i        (rdata)
  );

  sppe_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (dp_mem.re),
    .raddr_i (dp_raddr),
    .rdata_o (rdata)
  );

endmodule

>>> rtl/sppe_ram.sv
// ----------------------------------------------------------------------------
// sppe_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a read of the word being written).
// ----------------------------------------------------------------------------
module sppe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 131072
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sppe_ptr.sv
// ----------------------------------------------------------------------------
// sppe_ptr
// Configuration registers, offset reduction modulo DEPTH and the read and
// write pointers of the echo store.
// ----------------------------------------------------------------------------
module sppe_ptr #(
  parameter int DEPTH = 131072
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sppe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sppe_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              take_i,
  output logic                              busy_o,
  output logic [sppe_pkg::GAIN_W-1:0]       gain_o,
  output logic [$clog2(DEPTH)-1:0]          rp_o,
  output logic [$clog2(DEPTH)-1:0]          wl_o,
  output logic [$clog2(DEPTH)-1:0]          wr_o
);

  import sppe_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int M_W    = OFF_W + 1;
  localparam int PRD_W  = OFF_W + M_W;
  localparam int Q_SH   = OFF_W + AW;
  localparam int QD_W   = OFF_W + AW;
  localparam int OM_RST = int'(OFFSET_RESET) % DEPTH;
  localparam int T_RST  = (2 * OM_RST + 1) % DEPTH;
  localparam logic [AW:0] DEPTH_X = (AW+1)'(DEPTH);
  // floor(2^Q_SH / DEPTH) + 1 yields the exact quotient for any 18-bit offset
  localparam logic [M_W-1:0]  RECIP   = M_W'((longint'(1) << Q_SH) / longint'(DEPTH) + 1);
  localparam logic [QD_W-1:0] DEPTH_Q = QD_W'(DEPTH);

  typedef enum logic [1:0] {
    M_IDLE,
    M_MUL,
    M_SUB,
    M_FIN
  } mod_state_e;

  mod_state_e        state_q;
  logic [OFF_W-1:0]  q_q;
  logic [OFF_W-1:0]  rem_q;
  logic [OFF_W-1:0]  offset_q;
  logic [OFF_W-1:0]  applied_q;
  logic [GAIN_W-1:0] gain_q;
  logic [AW-1:0]     om_q;
  logic [AW-1:0]     two_q;
  logic [AW-1:0]     rp_q, wl_q, wr_q;

  logic              cfg_wr;
  logic [PRD_W-1:0]  prd;
  logic [QD_W-1:0]   qd;
  logic [AW-1:0]     om_d;
  logic [AW:0]       t2;
  logic [AW-1:0]     two_d;
  logic              stale;
  logic [AW:0]       dl, dr;
  logic [AW-1:0]     wl_new, wr_new;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign cfg_ready_o = (state_q == M_IDLE);
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign busy_o      = (state_q != M_IDLE);
  assign gain_o      = gain_q;

  // quotient by reciprocal multiplication, then remainder by one product
  assign prd = {{M_W{1'b0}}, offset_q} * {{OFF_W{1'b0}}, RECIP};
  assign qd  = {{AW{1'b0}}, q_q} * DEPTH_Q;

  assign om_d  = AW'(rem_q);
  assign t2    = {om_d, 1'b1};
  assign two_d = (t2 >= DEPTH_X) ? AW'(t2 - DEPTH_X) : AW'(t2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= M_IDLE;
      q_q      <= '0;
      rem_q    <= '0;
      offset_q <= OFFSET_RESET;
      gain_q   <= GAIN_RESET;
      om_q     <= AW'(OM_RST);
      two_q    <= AW'(T_RST);
    end else begin
      case (state_q)
        M_IDLE: begin
          if (cfg_wr) begin
            case (cfg_index_i)
              REG_DELAY_OFFSET: begin
                offset_q <= cfg_data_i[OFF_W-1:0];
                state_q  <= M_MUL;
              end
              REG_FEEDBACK_GAIN: gain_q <= cfg_data_i[GAIN_W-1:0];
              default: ;
            endcase
          end
        end
        M_MUL: begin
          q_q     <= OFF_W'(prd >> Q_SH);
          state_q <= M_SUB;
        end
        M_SUB: begin
          rem_q   <= offset_q - qd[OFF_W-1:0];
          state_q <= M_FIN;
        end
        M_FIN: begin
          om_q    <= om_d;
          two_q   <= two_d;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  // re-aim the write pointers behind the read pointer on an offset change
  assign stale  = (offset_q != applied_q);
  assign dl     = {1'b0, rp_q} + DEPTH_X - {1'b0, om_q};
  assign dr     = {1'b0, rp_q} + DEPTH_X - {1'b0, two_q};
  assign wl_new = (dl >= DEPTH_X) ? AW'(dl - DEPTH_X) : AW'(dl);
  assign wr_new = (dr >= DEPTH_X) ? AW'(dr - DEPTH_X) : AW'(dr);

  assign rp_o = rp_q;
  assign wl_o = stale ? wl_new : wl_q;
  assign wr_o = stale ? wr_new : wr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q      <= '0;
      wl_q      <= AW'(OM_RST);
      wr_q      <= AW'(DEPTH - 1);
      applied_q <= OFFSET_RESET;
    end else if (take_i) begin
      rp_q      <= wrap_inc(rp_q);
      wl_q      <= wrap_inc(wl_o);
      wr_q      <= wrap_inc(wr_o);
      applied_q <= offset_q;
    end
  end

endmodule

>>> rtl/sppe_dp.sv
// ----------------------------------------------------------------------------
// sppe_dp
// Per-sample sequencer and arithmetic: three store reads, dry and feedback
// products, two saturated write-backs, and a two-entry result buffer.
// ----------------------------------------------------------------------------
module sppe_dp #(
  parameter int DEPTH = 131072,
  parameter int SB    = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sppe_pkg::hold_t                     hold_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [sppe_pkg::IN_W-1:0]    in_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sppe_pkg::OUT_W-1:0]   left_sample_o,
  output logic signed [sppe_pkg::OUT_W-1:0]   right_sample_o,
  output logic                                take_o,
  input  logic [sppe_pkg::GAIN_W-1:0]         gain_i,
  input  logic [$clog2(DEPTH)-1:0]            rp_i,
  input  logic [$clog2(DEPTH)-1:0]            wl_i,
  input  logic [$clog2(DEPTH)-1:0]            wr_i,
  output sppe_pkg::mem_ctl_t                  mem_o,
  output logic [$clog2(DEPTH)-1:0]            raddr_o,
  output logic [$clog2(DEPTH)-1:0]            waddr_o,
  output logic [SB-1:0]                       wdata_o,
  input  logic [SB-1:0]                       rdata_i
);

  import sppe_pkg::*;

  localparam int AW      = $clog2(DEPTH);
  localparam int PR_W    = SB + GAIN_W + 1;
  localparam int ACC_W   = PR_W + 1;
  localparam int DRY_PW  = IN_W + 17;
  localparam int O_W     = ((SB > IN_W) ? SB : IN_W) + 2;
  localparam logic signed [ACC_W-1:0] W_MAX = ACC_W'((longint'(1) <<< (SB - 1)) - 1);
  localparam logic signed [ACC_W-1:0] W_MIN = ACC_W'(-(longint'(1) <<< (SB - 1)));
  localparam logic signed [O_W-1:0]   O_MAX = O_W'((longint'(1) <<< (OUT_W - 1)) - 1);
  localparam logic signed [O_W-1:0]   O_MIN = O_W'(-(longint'(1) <<< (OUT_W - 1)));
  localparam logic signed [PR_W-1:0]   RND16 = PR_W'(32768);
  localparam logic signed [PR_W-1:0]   RND17 = PR_W'(65536);
  localparam logic signed [DRY_PW-1:0] RND_DRY = DRY_PW'(32768);

  function automatic logic [SB-1:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > W_MAX) r = W_MAX;
    if (v < W_MIN) r = W_MIN;
    return r[SB-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [O_W-1:0] v);
    logic signed [O_W-1:0] r;
    r = v;
    if (v > O_MAX) r = O_MAX;
    if (v < O_MIN) r = O_MIN;
    return r[OUT_W-1:0];
  endfunction

  // stage valids: s1..s3 front reads, s4..s5 right write-back tail
  logic s1_q, s2_q, s3_q, s4_q, s5_q;
  logic [1:0] n_q;  // requests in flight plus results buffered

  logic signed [IN_W-1:0]  x_q, t_x_q, dry_q;
  logic [AW-1:0]           rp_s_q, wl_s_q, wr_s_q, t_wr_q;
  logic                    t_same_q;
  logic signed [SB-1:0]    tap_q, oldl_q, oldr_q, lnew_q;
  logic signed [PR_W-1:0]  prodl_q, prodr_q;
  logic                    fwd_q;
  logic [SB-1:0]           fwd_data_q;

  logic                    can_take, pop;
  logic signed [SB-1:0]    rd_word;
  logic signed [GAIN_W:0]  gain_s;
  logic signed [16:0]      dry_k;
  logic signed [DRY_PW-1:0] dry_prod;
  logic signed [ACC_W-1:0] acc_l, acc_r;
  logic [SB-1:0]           left_new, right_new;
  logic signed [O_W-1:0]   sum_l, sum_r;
  logic signed [SB-1:0]    oldr_eff;

  logic [OUT_W-1:0] ob_l_q [2];
  logic [OUT_W-1:0] ob_r_q [2];
  logic             ob_wp_q, ob_rp_q;
  logic [1:0]       ob_cnt_q;

  assign can_take   = !hold_i.clear && !hold_i.cfg_busy && !s1_q && !s2_q && !s3_q
                      && (n_q < 2'd2);
  assign in_stall_o = !can_take;
  assign take_o     = in_valid_i && can_take;
  assign pop        = out_valid_o && !out_stall_i;

  assign rd_word  = fwd_q ? $signed(fwd_data_q) : $signed(rdata_i);
  assign gain_s   = $signed({1'b0, gain_i});
  assign dry_k    = $signed({1'b0, DRY_GAIN});
  assign dry_prod = x_q * dry_k;

  // read port: read tap, left slot, right slot on consecutive cycles
  always_comb begin
    mem_o.re = 1'b0;
    raddr_o  = rp_i;
    if (take_o) begin
      mem_o.re = 1'b1;
    end else if (s1_q) begin
      mem_o.re = 1'b1;
      raddr_o  = wl_s_q;
    end else if (s2_q) begin
      mem_o.re = 1'b1;
      raddr_o  = wr_s_q;
    end
  end

  assign acc_l    = ACC_W'(x_q) + ACC_W'((prodl_q + RND16) >>> 16);
  assign acc_r    = ACC_W'(t_x_q) + ACC_W'((prodr_q + RND17) >>> 17);
  assign left_new  = sat_word(acc_l);
  assign right_new = sat_word(acc_r);

  // write port: left slot at s3, right slot at s5, never together
  always_comb begin
    mem_o.we = s3_q || s5_q;
    waddr_o  = s5_q ? t_wr_q : wl_s_q;
    wdata_o  = s5_q ? right_new : left_new;
  end

  assign sum_l = O_W'(dry_q) + O_W'(tap_q) + O_W'(oldl_q);
  assign sum_r = O_W'(dry_q) + O_W'(tap_q) + O_W'(rd_word);

  // right slot sees the fresh left word when both pointers coincide
  assign oldr_eff = t_same_q ? lnew_q : oldr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= 1'b0;
      s2_q  <= 1'b0;
      s3_q  <= 1'b0;
      s4_q  <= 1'b0;
      s5_q  <= 1'b0;
      n_q   <= '0;
      fwd_q <= 1'b0;
    end else begin
      s1_q  <= take_o;
      s2_q  <= s1_q;
      s3_q  <= s2_q;
      s4_q  <= s3_q;
      s5_q  <= s4_q;
      n_q   <= n_q + {1'b0, take_o} - {1'b0, pop};
      fwd_q <= mem_o.re && mem_o.we && (raddr_o == waddr_o);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata_o;
    if (take_o) begin
      x_q    <= in_sample_i;
      rp_s_q <= rp_i;
      wl_s_q <= wl_i;
      wr_s_q <= wr_i;
    end
    if (s1_q) begin
      // the previous right write-back may land now; take it when it hits the tap
      tap_q <= (s5_q && (rp_s_q == t_wr_q)) ? $signed(right_new) : rd_word;
      dry_q <= IN_W'((dry_prod + RND_DRY) >>> 16);
    end
    if (s2_q) begin
      oldl_q  <= rd_word;
      prodl_q <= rd_word * gain_s;
    end
    if (s3_q) begin
      oldr_q   <= rd_word;
      lnew_q   <= left_new;
      t_x_q    <= x_q;
      t_wr_q   <= wr_s_q;
      t_same_q <= (wl_s_q == wr_s_q);
    end
    if (s4_q) begin
      prodr_q <= oldr_eff * gain_s;
    end
  end

  // result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wp_q  <= 1'b0;
      ob_rp_q  <= 1'b0;
      ob_cnt_q <= '0;
    end else begin
      if (s3_q) ob_wp_q <= !ob_wp_q;
      if (pop)  ob_rp_q <= !ob_rp_q;
      ob_cnt_q <= ob_cnt_q + {1'b0, s3_q} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_q) begin
      ob_l_q[ob_wp_q] <= sat_out(sum_l);
      ob_r_q[ob_wp_q] <= sat_out(sum_r);
    end
  end

  assign out_valid_o    = (ob_cnt_q != '0);
  assign left_sample_o  = $signed(ob_l_q[ob_rp_q]);
  assign right_sample_o = $signed(ob_r_q[ob_rp_q]);

endmodule

>>> rtl/sppe_chk.sv
// ----------------------------------------------------------------------------
// sppe_chk
// Port-level checks for the stereo ping-pong echo, bound to the top level.
// ----------------------------------------------------------------------------
module sppe_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic signed [sppe_pkg::IN_W-1:0]    in_sample_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [sppe_pkg::OUT_W-1:0]   left_sample_o,
  input logic signed [sppe_pkg::OUT_W-1:0]   right_sample_o,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic [sppe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input logic [sppe_pkg::CFG_W-1:0]          cfg_data_i
);

  import sppe_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(left_sample_o) && $stable(right_sample_o))
    else $error("stalled result changed");

  // after a request is taken, no other is taken while it is in s1 to s3
  a_in_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("request accepted inside the four-cycle slot");

  // an offset write blocks config and requests while it is reduced
  a_offset_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_DELAY_OFFSET) |=>
      !cfg_ready_o && in_stall_o)
    else $error("offset reduction not interlocked");

  // a result from an empty buffer comes from an accepted request that passed s1 to s3
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 4))
    else $error("result without matching request");

endmodule

bind stereo_ping_pong_echo sppe_chk u_chk (.*);
